// File: sv/weekday_by_date_walk_macros.svh
// ----------------------------------------------------------------------------
// weekday_by_date_walk assertion macros
// Shared concurrent-assertion shorthands for the block's checker.
// ----------------------------------------------------------------------------
`ifndef WEEKDAY_BY_DATE_WALK_MACROS_SVH
`define WEEKDAY_BY_DATE_WALK_MACROS_SVH

// same-cycle implication, off during reset
`define WDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define WDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always checked
`define WDW_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/wdw_pkg.sv
// ----------------------------------------------------------------------------
// wdw_pkg
// Types, calendar constants and date helpers for the weekday walker.
// ----------------------------------------------------------------------------
package wdw_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int WD_W   = 3;
    localparam int MAXY_W = 16;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    localparam logic [WD_W-1:0]   WD_NONE   = 3'd0;
    localparam logic [WD_W-1:0]   WD_MON    = 3'd1;
    localparam logic [WD_W-1:0]   WD_SUN    = 3'd7;
    localparam logic [MON_W-1:0]  MON_JAN   = 4'd1;
    localparam logic [MON_W-1:0]  MON_FEB   = 4'd2;
    localparam logic [MON_W-1:0]  MON_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]  DAYS_28   = 5'd28;
    localparam logic [DAY_W-1:0]  DAYS_29   = 5'd29;
    localparam logic [DAY_W-1:0]  DAYS_30   = 5'd30;
    localparam logic [DAY_W-1:0]  DAYS_31   = 5'd31;

    // y divisible by 25 <=> (y * 25^-1 mod 2^14) <= (2^14-1)/25
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'((2**YEAR_W - 1) / 25);

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } t_date;

    typedef struct packed {
        logic [DAY_W-1:0]  known_day;
        logic [MON_W-1:0]  known_month;
        logic [YEAR_W-1:0] known_year;
        logic [WD_W-1:0]   known_weekday;
        logic [DAY_W-1:0]  target_day;
        logic [MON_W-1:0]  target_month;
        logic [YEAR_W-1:0] target_year;
    } t_req;

    typedef struct packed {
        logic [WD_W-1:0] weekday;
        logic            invalid;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic fwd;
    } t_step_ctl;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        // div by 4 and (not by 100, or by 400 = by 16 and 25)
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MON_FEB:                  len = leap ? DAYS_29 : DAYS_28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = DAYS_30;
            default:                  len = DAYS_31;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(input t_date dt, input logic [MAXY_W-1:0] max_year);
        logic ok;
        ok = 1'b1;
        if (dt.year == '0 || MAXY_W'(dt.year) > max_year)
            ok = 1'b0;
        if (dt.month == '0 || dt.month > MON_DEC)
            ok = 1'b0;
        else if (dt.day == '0 || dt.day > month_len(dt.month, is_leap(dt.year)))
            ok = 1'b0;
        return ok;
    endfunction

endpackage

// File: sv/weekday_by_date_walk.sv
// The stepper moves a day a cycle. An accepted request is registered, checked
// and walked over the N days from the known date to the target (up to about
// 3.65 million); a rejected date goes from the check straight to the output.
// The input stalls until the result, held by output stalls, has left S_OUT.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// pending result.
// ----------------------------------------------------------------------------
// weekday_by_date_walk
// Weekday of a target date by walking day by day from a known date.
// ----------------------------------------------------------------------------
module weekday_by_date_walk
    import wdw_pkg::*;
#(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out
);

    localparam logic [MAXY_W-1:0] MAX_Y = MAXY_W'(MAX_YEAR);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_WALK  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic            r_fwd, n_fwd;
    t_rsp            r_res, n_res;
    t_rsp            r_out, n_out;
    logic            r_out_valid, n_out_valid;

    t_date           known_date, tgt_date, cur_date;
    logic [WD_W-1:0] cur_wd;
    logic            dates_ok, fwd, at_target;
    t_step_ctl       step_ctl;

    assign known_date = '{day: r_req.known_day, month: r_req.known_month,
                          year: r_req.known_year};
    assign tgt_date   = '{day: r_req.target_day, month: r_req.target_month,
                          year: r_req.target_year};

    assign dates_ok  = (r_req.known_weekday != WD_NONE) && date_ok(known_date, MAX_Y)
                       && date_ok(tgt_date, MAX_Y);
    assign fwd       = {known_date.year, known_date.month, known_date.day}
                       < {tgt_date.year, tgt_date.month, tgt_date.day};
    assign at_target = (cur_date == tgt_date);

    assign step_ctl.load = (r_state == S_CHECK);
    assign step_ctl.step = (r_state == S_WALK) && !at_target;
    assign step_ctl.fwd  = r_fwd;

    wdw_step u_step (
        .i_clk       (i_clk),
        .i_ctl       (step_ctl),
        .i_load_date (known_date),
        .i_load_wd   (r_req.known_weekday),
        .o_date      (cur_date),
        .o_wd        (cur_wd)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_fwd       = r_fwd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (dates_ok) begin
                    n_fwd   = fwd;
                    n_state = S_WALK;
                end else begin
                    n_res   = '{weekday: WD_NONE, invalid: 1'b1};
                    n_state = S_OUT;
                end
            end
            S_WALK: begin
                if (at_target) begin
                    n_res   = '{weekday: cur_wd, invalid: 1'b0};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_fwd <= n_fwd;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sv/wdw_step.sv
// ----------------------------------------------------------------------------
// wdw_step
// Day stepper: holds the walking date and weekday, moves one day per step.
// ----------------------------------------------------------------------------
module wdw_step
    import wdw_pkg::*;
(
    input  logic            i_clk,
    input  t_step_ctl       i_ctl,
    input  t_date           i_load_date,
    input  logic [WD_W-1:0] i_load_wd,
    output t_date           o_date,
    output logic [WD_W-1:0] o_wd
);

    t_date            r_date, n_date;
    logic [WD_W-1:0]  r_wd, n_wd;
    logic             leap;
    logic [DAY_W-1:0] cur_len;
    logic [DAY_W-1:0] prev_len;

    always_comb begin
        leap     = is_leap(r_date.year);
        cur_len  = month_len(r_date.month, leap);
        prev_len = month_len(r_date.month - MON_JAN, leap);
        n_date   = r_date;
        n_wd     = r_wd;
        if (i_ctl.load) begin
            n_date = i_load_date;
            n_wd   = i_load_wd;
        end else if (i_ctl.step) begin
            if (i_ctl.fwd) begin
                n_wd = (r_wd == WD_SUN) ? WD_MON : r_wd + 1'b1;
                if (r_date.day == cur_len) begin
                    n_date.day = DAY_FIRST;
                    if (r_date.month == MON_DEC) begin
                        n_date.month = MON_JAN;
                        n_date.year  = r_date.year + 1'b1;
                    end else begin
                        n_date.month = r_date.month + 1'b1;
                    end
                end else begin
                    n_date.day = r_date.day + 1'b1;
                end
            end else begin
                n_wd = (r_wd == WD_MON) ? WD_SUN : r_wd - 1'b1;
                if (r_date.day == DAY_FIRST) begin
                    if (r_date.month == MON_JAN) begin
                        n_date.month = MON_DEC;
                        n_date.day   = DAYS_31;
                        n_date.year  = r_date.year - 1'b1;
                    end else begin
                        n_date.month = r_date.month - 1'b1;
                        n_date.day   = prev_len;
                    end
                end else begin
                    n_date.day = r_date.day - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_date <= n_date;
        r_wd   <= n_wd;
    end

    assign o_date = r_date;
    assign o_wd   = r_wd;

endmodule

// File: sv/wdw_chk.sv
// ----------------------------------------------------------------------------
// wdw_chk
// Port-level checks for the weekday walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "weekday_by_date_walk_macros.svh"

module wdw_chk
    import wdw_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input t_rsp i_out
);

    // one request in flight: an accepted request closes the input
    `WDW_ASSERT_NXT(a_one_req, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall, "request accepted while busy")

    // weekday zero marks exactly the rejected requests
    `WDW_ASSERT_IMP(a_inv_wd, i_clk, i_rst_n, i_out_valid, i_out.invalid == (i_out.weekday == WD_NONE), "invalid flag and weekday disagree")

    `WDW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "stalled result changed")

    `WDW_ASSERT_NXT_ALL(a_rst_out, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind weekday_by_date_walk wdw_chk u_wdw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

// File: test/weekday_by_date_walk_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekday_by_date_walk_test
// Drives date pairs through the weekday walker under random bursts, gaps and
// output stalls, and checks every result against a day-count calculation.
// ----------------------------------------------------------------------------
module weekday_by_date_walk_test;
    import wdw_pkg::*;

    localparam logic [WD_W-1:0] WD_TUE = 3'd2;
    localparam logic [WD_W-1:0] WD_WED = 3'd3;
    localparam logic [WD_W-1:0] WD_FRI = 3'd5;
    localparam logic [WD_W-1:0] WD_SAT = 3'd6;

    localparam int RAND_ITEMS = 80;
    localparam int DRAIN_GAP  = 50;     // second drain point, past the directed part
    localparam int HOLD_AT    = 40;     // result count that starts the long hold-off
    localparam int LONG_HOLD  = 12_000;
    localparam int TAIL_WAIT  = 10;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_req i_in        = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out;

    t_req pending_q[$];
    t_rsp weekday_q[$];

    int  directed_n = 0;
    int  req_count  = 0;
    int  rsp_count  = 0;
    int  mismatches = 0;
    int  burst_left = 0;
    int  gap_left   = 0;
    int  hold_left  = 0;
    int  mode_left  = 0;
    bit  busy_mode  = 1'b0;
    bit  held_once  = 1'b0;
    bit  took;
    int  taken;
    t_rsp want;

    weekday_by_date_walk dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- calendar arithmetic ----------------

    function automatic bit leap_year(int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic int days_of_month(int m, int y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit calendar_ok(int d, int m, int y);
        if (y < 1 || y > MAX_YEAR_DEF || m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= days_of_month(m, y);
    endfunction

    // days since 1 Jan of year 1
    function automatic longint serial_day(int d, int m, int y);
        longint p;
        longint n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int k = 1; k < m; k++)
            n += days_of_month(k, y);
        return n + d - 1;
    endfunction

    function automatic t_rsp calc_weekday(t_req r);
        t_rsp   res;
        longint nk;
        longint nt;
        res.weekday = WD_NONE;
        res.invalid = 1'b1;
        if (r.known_weekday == WD_NONE
            || !calendar_ok(r.known_day, r.known_month, r.known_year)
            || !calendar_ok(r.target_day, r.target_month, r.target_year))
            return res;
        nk = serial_day(r.known_day, r.known_month, r.known_year) % 7;
        nt = serial_day(r.target_day, r.target_month, r.target_year) % 7;
        res.weekday = WD_W'((longint'(r.known_weekday) - 1 + nt - nk + 7) % 7 + 1);
        res.invalid = 1'b0;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_req date_pair(int kd, int km, int ky, int kw,
                                       int td, int tm, int ty);
        t_req r;
        r.known_day     = DAY_W'(kd);
        r.known_month   = MON_W'(km);
        r.known_year    = YEAR_W'(ky);
        r.known_weekday = WD_W'(kw);
        r.target_day    = DAY_W'(td);
        r.target_month  = MON_W'(tm);
        r.target_year   = YEAR_W'(ty);
        return r;
    endfunction

    function automatic int pick_year();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 4);
            1:       return $urandom_range(MAX_YEAR_DEF - 3, MAX_YEAR_DEF);
            2:       return 100 * $urandom_range(1, 99) + $urandom_range(0, 2) - 1;
            default: return $urandom_range(1, MAX_YEAR_DEF);
        endcase
    endfunction

    function automatic t_date pick_date(int y);
        t_date dt;
        int    m;
        m        = $urandom_range(1, 12);
        dt.year  = YEAR_W'(y);
        dt.month = MON_W'(m);
        dt.day   = DAY_W'($urandom_range(1, days_of_month(m, y)));
        return dt;
    endfunction

    // well-formed pair: target within a few years of the reference, mostly
    function automatic t_req near_pair();
        t_req  r;
        t_date kd;
        t_date td;
        int    ky;
        int    ty;
        ky = pick_year();
        kd = pick_date(ky);
        case ($urandom_range(0, 9))
            0:       ty = ky + int'($urandom_range(0, 30)) - 15;
            1:       ty = ky;
            default: ty = ky + int'($urandom_range(0, 4)) - 2;
        endcase
        if (ty < 1)
            ty = 1;
        if (ty > MAX_YEAR_DEF)
            ty = MAX_YEAR_DEF;
        td = pick_date(ty);
        if (ty == ky && $urandom_range(0, 3) == 0)
            td.month = kd.month;
        if (td.day > days_of_month(td.month, ty))
            td.day = DAY_W'(days_of_month(td.month, ty));
        r = date_pair(kd.day, kd.month, kd.year, $urandom_range(1, 7),
                      td.day, td.month, td.year);
        return r;
    endfunction

    // random bits with at least one field forced out of range
    function automatic t_req broken_pair();
        t_req      r;
        bit [63:0] raw;
        int        m;
        raw = {$urandom, $urandom};
        r   = raw[$bits(t_req)-1:0];
        case ($urandom_range(0, 5))
            0: r.known_weekday = WD_NONE;
            1: r.known_month   = ($urandom_range(0, 1) == 0) ? '0 : MON_W'($urandom_range(13, 15));
            2: r.target_day    = '0;
            3: r.known_year    = ($urandom_range(0, 1) == 0) ? '0
                                 : YEAR_W'($urandom_range(MAX_YEAR_DEF + 1, 2**YEAR_W - 1));
            4: r.target_month  = ($urandom_range(0, 1) == 0) ? '0 : MON_W'($urandom_range(13, 15));
            default: begin
                // day past the end of a short month
                case ($urandom_range(0, 4))
                    0:       m = 2;
                    1:       m = 4;
                    2:       m = 6;
                    3:       m = 9;
                    default: m = 11;
                endcase
                r.target_month = MON_W'(m);
                r.target_day   = DAY_W'($urandom_range(days_of_month(m, r.target_year) + 1, 31));
            end
        endcase
        return r;
    endfunction

    // ---------------- request driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            req_count  <= 0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took)
                weekday_q.push_back(calc_weekday(i_in));
            taken = req_count + int'(took);
            req_count <= taken;
            if (!i_in_valid || took) begin
                if (gap_left > 0) begin
                    i_in_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end else if (pending_q.size() == 0
                             || ((taken == directed_n || taken == directed_n + DRAIN_GAP)
                                 && taken != rsp_count)) begin
                    // out of work, or waiting for the block to drain
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in       <= pending_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ---------------- result monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rsp_count   <= 0;
            hold_left   <= 0;
            mode_left   <= 0;
            busy_mode   <= 1'b0;
            held_once   <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                rsp_count <= rsp_count + 1;
                if (weekday_q.size() == 0) begin
                    $error("unexpected result: weekday %0d invalid %0b",
                           o_out.weekday, o_out.invalid);
                    mismatches++;
                end else begin
                    want = weekday_q.pop_front();
                    if (o_out.weekday !== want.weekday) begin
                        $error("weekday: expected %0d, got %0d", want.weekday, o_out.weekday);
                        mismatches++;
                    end
                    if (o_out.invalid !== want.invalid) begin
                        $error("invalid: expected %0b, got %0b", want.invalid, o_out.invalid);
                        mismatches++;
                    end
                end
            end

            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else if (!held_once && rsp_count == HOLD_AT) begin
                // long hold-off so the block backs up into its input
                i_out_stall <= 1'b1;
                hold_left   <= LONG_HOLD;
                held_once   <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    busy_mode <= 1'($urandom_range(0, 1));
                    mode_left <= $urandom_range(20, 200);
                end else begin
                    mode_left <= mode_left - 1;
                end
                i_out_stall <= busy_mode && ($urandom_range(0, 2) == 0);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        // equal dates, year extremes, wrap in both directions
        pending_q.push_back(date_pair(1, 1, 1, WD_MON, 1, 1, 1));
        pending_q.push_back(date_pair(1, 1, 1, WD_MON, 31, 12, 1));
        pending_q.push_back(date_pair(31, 12, MAX_YEAR_DEF, WD_FRI, 1, 1, MAX_YEAR_DEF));
        pending_q.push_back(date_pair(30, 11, MAX_YEAR_DEF, WD_TUE, 31, 12, MAX_YEAR_DEF));
        pending_q.push_back(date_pair(1, 1, 2023, WD_SUN, 31, 12, 2022));
        pending_q.push_back(date_pair(1, 1, 2023, WD_SUN, 2, 1, 2023));
        pending_q.push_back(date_pair(2, 1, 2023, WD_MON, 1, 1, 2023));
        pending_q.push_back(date_pair(31, 12, 2023, WD_SUN, 1, 1, 2024));
        // leap rules: 400-year, 4-year, century
        pending_q.push_back(date_pair(29, 2, 2000, WD_TUE, 1, 3, 2000));
        pending_q.push_back(date_pair(1, 3, 2024, WD_FRI, 29, 2, 2024));
        pending_q.push_back(date_pair(28, 2, 1900, WD_WED, 1, 3, 1900));
        // one full 400-year cycle
        pending_q.push_back(date_pair(1, 1, 2000, WD_SAT, 1, 1, 2400));
        // rejected inputs
        pending_q.push_back(date_pair(5, 5, 2020, WD_NONE, 6, 5, 2020));
        pending_q.push_back(date_pair(5, 0, 2020, WD_MON, 6, 5, 2020));
        pending_q.push_back(date_pair(5, 15, 2020, WD_MON, 6, 13, 2020));
        pending_q.push_back(date_pair(0, 5, 2020, WD_MON, 6, 5, 2020));
        pending_q.push_back(date_pair(5, 5, 2020, WD_MON, 31, 4, 2020));
        pending_q.push_back(date_pair(29, 2, 1900, WD_MON, 1, 3, 1900));
        pending_q.push_back(date_pair(1, 3, 2000, WD_MON, 30, 2, 2000));
        pending_q.push_back(date_pair(1, 1, 0, WD_MON, 1, 1, 1));
        pending_q.push_back(date_pair(1, 1, MAX_YEAR_DEF, WD_MON, 1, 1, MAX_YEAR_DEF + 1));
        pending_q.push_back(date_pair(1, 1, 2020, WD_SUN, 31, 15, 2**YEAR_W - 1));
        pending_q.push_back(date_pair(1, 11, 2020, WD_SUN, 31, 11, 2020));
        directed_n = pending_q.size();

        for (int i = 0; i < RAND_ITEMS; i++)
            pending_q.push_back(($urandom_range(0, 4) == 0) ? broken_pair() : near_pair());

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_in_valid || weekday_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (weekday_q.size() != 0) begin
            $error("%0d results never arrived", weekday_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/wdw_pkg.sv
sv/wdw_step.sv
sv/weekday_by_date_walk.sv
sv/wdw_chk.sv
test/weekday_by_date_walk_test.sv
